@@ rtl/tods_pkg.sv @@
// ----------------------------------------------------------------------------
// tods_pkg
// Types and constants shared by the dimmer schedule core and its ramp unit.
// ----------------------------------------------------------------------------
package tods_pkg;

    localparam int HourWidth      = 5;
    localparam int MinuteWidth    = 6;
    localparam int LevelWidth     = 7;
    localparam int WindowWidth    = 3;
    localparam int MinuteDayWidth = 11;
    localparam int AccWidth       = 18;
    localparam int DividendWidth  = AccWidth + 1;
    localparam int CfgIndexWidth  = 3;

    typedef logic [HourWidth-1:0]      t_hour;
    typedef logic [MinuteWidth-1:0]    t_minute;
    typedef logic [LevelWidth-1:0]     t_level;
    typedef logic [WindowWidth-1:0]    t_window;
    typedef logic [MinuteDayWidth-1:0] t_minute_of_day;
    typedef logic [AccWidth-1:0]       t_ramp_acc;
    typedef logic [CfgIndexWidth-1:0]  t_cfg_index;

    localparam t_window WIN_NIGHT   = 3'd0;
    localparam t_window WIN_MORNING = 3'd1;
    localparam t_window WIN_DAY     = 3'd2;
    localparam t_window WIN_EVENING = 3'd3;
    localparam t_window WIN_UNKNOWN = 3'd4;

    localparam t_level INVALID_TIME_LEVEL = 7'd25;
    localparam t_level LEVEL_MAX          = 7'd100;
    localparam t_hour  HOUR_MAX           = 5'd23;

    localparam t_cfg_index REG_MORNING_BEGIN_HOUR  = 3'd0;
    localparam t_cfg_index REG_DAY_BEGIN_HOUR      = 3'd1;
    localparam t_cfg_index REG_EVENING_BEGIN_HOUR  = 3'd2;
    localparam t_cfg_index REG_NIGHT_BEGIN_HOUR    = 3'd3;
    localparam t_cfg_index REG_MORNING_LEVEL       = 3'd4;
    localparam t_cfg_index REG_DAY_LEVEL           = 3'd5;
    localparam t_cfg_index REG_EVENING_FIRST_LEVEL = 3'd6;
    localparam t_cfg_index REG_EVENING_LAST_LEVEL  = 3'd7;

    typedef struct packed {
        t_hour   hour;
        t_minute minute;
        logic    time_valid;
    } t_in_item;

    typedef struct packed {
        t_level  target_level;
        t_level  shown_level;
        t_window window;
    } t_out_item;

    typedef struct packed {
        t_cfg_index index;
        t_level     value;
    } t_cfg_write;

    // Ramp job: result = round((coef_a*op_a + coef_b*op_b) / den), half up
    typedef struct packed {
        t_level         coef_a;
        t_level         coef_b;
        t_minute_of_day op_a;
        t_minute_of_day op_b;
        t_minute_of_day den;
    } t_ramp_req;

endpackage

@@ rtl/tods_stream_if.sv @@
// ----------------------------------------------------------------------------
// tods_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface tods_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/tods_ramp_unit.sv @@
// ----------------------------------------------------------------------------
// tods_ramp_unit
// Bit-serial shift-add product of two terms, then bit-serial restoring
// division with half-up rounding. One coefficient bit, then one dividend
// bit, per cycle.
// ----------------------------------------------------------------------------
module tods_ramp_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  tods_pkg::t_ramp_req        i_req,
    output logic                       o_done,
    output tods_pkg::t_level           o_quotient
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;
    localparam logic [1:0] S_DIV  = 2'd3;

    localparam int DenWidth = tods_pkg::MinuteDayWidth + 1;
    localparam int LvlW     = tods_pkg::LevelWidth;
    localparam int DvdW     = tods_pkg::DividendWidth;

    logic [1:0]                     r_state, n_state;
    logic [4:0]                     r_cnt, n_cnt;
    logic                           r_done, n_done;
    tods_pkg::t_level               r_coef_a, n_coef_a;
    tods_pkg::t_level               r_coef_b, n_coef_b;
    tods_pkg::t_minute_of_day       r_op_a, n_op_a;
    tods_pkg::t_minute_of_day       r_op_b, n_op_b;
    tods_pkg::t_minute_of_day       r_den, n_den;
    tods_pkg::t_ramp_acc            r_acc, n_acc;
    logic [DvdW-1:0]                r_dvd, n_dvd;
    logic [DenWidth-1:0]            r_rem, n_rem;
    tods_pkg::t_level               r_quo, n_quo;

    logic [DenWidth:0]              trial;
    logic [DenWidth:0]              divisor;
    logic                           q_bit;
    tods_pkg::t_ramp_acc            add_a;
    tods_pkg::t_ramp_acc            add_b;

    always_comb begin
        add_a   = r_coef_a[LvlW-1] ? tods_pkg::AccWidth'(r_op_a) : '0;
        add_b   = r_coef_b[LvlW-1] ? tods_pkg::AccWidth'(r_op_b) : '0;
        trial   = {r_rem, r_dvd[DvdW-1]};
        divisor = (DenWidth+1)'({r_den, 1'b0});
        q_bit   = (trial >= divisor);
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_done   = 1'b0;
        n_coef_a = r_coef_a;
        n_coef_b = r_coef_b;
        n_op_a   = r_op_a;
        n_op_b   = r_op_b;
        n_den    = r_den;
        n_acc    = r_acc;
        n_dvd    = r_dvd;
        n_rem    = r_rem;
        n_quo    = r_quo;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_coef_a = i_req.coef_a;
                    n_coef_b = i_req.coef_b;
                    n_op_a   = i_req.op_a;
                    n_op_b   = i_req.op_b;
                    n_den    = i_req.den;
                    n_acc    = '0;
                    n_cnt    = 5'(LvlW - 1);
                    n_state  = S_MUL;
                end
            end
            S_MUL: begin
                n_acc    = {r_acc[tods_pkg::AccWidth-2:0], 1'b0} + add_a + add_b;
                n_coef_a = {r_coef_a[LvlW-2:0], 1'b0};
                n_coef_b = {r_coef_b[LvlW-2:0], 1'b0};
                if (r_cnt == '0) begin
                    n_state = S_LOAD;
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end
            S_LOAD: begin
                n_dvd   = {r_acc, 1'b0} + DvdW'(r_den);
                n_rem   = '0;
                n_quo   = '0;
                n_cnt   = 5'(DvdW - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = q_bit ? DenWidth'(trial - divisor) : DenWidth'(trial);
                n_dvd = {r_dvd[DvdW-2:0], 1'b0};
                n_quo = {r_quo[LvlW-2:0], q_bit};
                if (r_cnt == '0) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_coef_a <= n_coef_a;
        r_coef_b <= n_coef_b;
        r_op_a   <= n_op_a;
        r_op_b   <= n_op_b;
        r_den    <= n_den;
        r_acc    <= n_acc;
        r_dvd    <= n_dvd;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ rtl/time_of_day_dimmer_schedule_core.sv @@
// ----------------------------------------------------------------------------
// time_of_day_dimmer_schedule_core
// Time-of-day brightness schedule with linear ramps and a faded output level.
//
// Channels: i_item takes one render tick (hour, minute, time_valid); o_result
// gives one item per tick (target_level, shown_level, window); i_cfg writes
// one schedule register per handshake and is always ready. Hour writes use the
// low five bits of the value, saturated above 23; levels above 100 are
// saturated on write. A tick in a morning or evening ramp waits between
// accept and result for the serial ramp unit (7 multiply steps, one load, 19
// divide steps). Night, day and unknown-time ticks go straight from classify
// to the done state. The next tick is accepted only after the previous result
// has been loaded into the output register.
// One tick is in flight at a time; i_item.ready is high while idle.
// A finished result waits in the output register; the next tick is accepted
// meanwhile and holds in its final step until the output register frees.
// Reset loads the default schedule and sets the shown level to zero.
// ----------------------------------------------------------------------------
module time_of_day_dimmer_schedule_core #(
    parameter int FADE_INCREMENT = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tods_stream_if.sink   i_item,
    tods_stream_if.sink   i_cfg,
    tods_stream_if.source o_result
);

    localparam logic [1:0] S_IDLE     = 2'd0;
    localparam logic [1:0] S_CLASSIFY = 2'd1;
    localparam logic [1:0] S_RAMP     = 2'd2;
    localparam logic [1:0] S_DONE     = 2'd3;

    localparam tods_pkg::t_level FadeStep = tods_pkg::LevelWidth'(FADE_INCREMENT);

    logic [1:0]                r_state, n_state;
    tods_pkg::t_minute_of_day  r_mod;
    logic                      r_time_valid;
    tods_pkg::t_level          r_target, n_target;
    tods_pkg::t_window         r_window, n_window;
    tods_pkg::t_level          r_faded;
    logic                      r_out_valid;
    tods_pkg::t_out_item       r_out_item;
    logic                      r_ramp_start, n_ramp_start;
    tods_pkg::t_ramp_req       r_ramp_req, n_ramp_req;

    tods_pkg::t_hour           r_morning_hour, r_day_hour, r_evening_hour, r_night_hour;
    tods_pkg::t_level          r_morning_level, r_day_level;
    tods_pkg::t_level          r_evening_first, r_evening_last;

    tods_pkg::t_minute_of_day  mo, dy, ev, ni;
    tods_pkg::t_level          faded_next;
    tods_pkg::t_hour           cfg_hour;
    tods_pkg::t_level          cfg_level;
    logic                      ramp_done;
    tods_pkg::t_level          ramp_quotient;
    logic                      out_free;

    function automatic tods_pkg::t_minute_of_day hour_minutes(input tods_pkg::t_hour h);
        return {h, 6'b0} - tods_pkg::MinuteDayWidth'({h, 2'b0});
    endfunction

    function automatic tods_pkg::t_level fade_toward(input tods_pkg::t_level cur,
                                                     input tods_pkg::t_level tgt);
        tods_pkg::t_level res;
        res = cur;
        if (cur < tgt) begin
            res = ((tgt - cur) <= FadeStep) ? tgt : cur + FadeStep;
        end else if (cur > tgt) begin
            res = ((cur - tgt) <= FadeStep) ? tgt : cur - FadeStep;
        end
        return res;
    endfunction

    always_comb begin
        mo         = hour_minutes(r_morning_hour);
        dy         = hour_minutes(r_day_hour);
        ev         = hour_minutes(r_evening_hour);
        ni         = hour_minutes(r_night_hour);
        faded_next = fade_toward(r_faded, r_target);
        out_free   = !r_out_valid || o_result.ready;
        cfg_hour   = (i_cfg.data.value[4:0] > tods_pkg::HOUR_MAX) ?
                     tods_pkg::HOUR_MAX : i_cfg.data.value[4:0];
        cfg_level  = (i_cfg.data.value > tods_pkg::LEVEL_MAX) ?
                     tods_pkg::LEVEL_MAX : i_cfg.data.value;
    end

    // Classify the minute of day and sequence the tick
    always_comb begin
        n_state      = r_state;
        n_target     = r_target;
        n_window     = r_window;
        n_ramp_start = 1'b0;
        n_ramp_req   = r_ramp_req;
        case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_state = S_CLASSIFY;
                end
            end
            S_CLASSIFY: begin
                n_state  = S_DONE;
                n_target = '0;
                n_window = tods_pkg::WIN_NIGHT;
                if (!r_time_valid) begin
                    n_target = tods_pkg::INVALID_TIME_LEVEL;
                    n_window = tods_pkg::WIN_UNKNOWN;
                end else if (r_mod >= ni || r_mod < mo) begin
                    n_window = tods_pkg::WIN_NIGHT;
                end else if (r_mod < dy) begin
                    n_window          = tods_pkg::WIN_MORNING;
                    n_ramp_req.coef_a = r_morning_level;
                    n_ramp_req.coef_b = '0;
                    n_ramp_req.op_a   = r_mod - mo;
                    n_ramp_req.op_b   = '0;
                    n_ramp_req.den    = dy - mo;
                    n_ramp_start      = 1'b1;
                    n_state           = S_RAMP;
                end else if (r_mod < ev) begin
                    n_target = r_day_level;
                    n_window = tods_pkg::WIN_DAY;
                end else begin
                    n_window          = tods_pkg::WIN_EVENING;
                    n_ramp_req.coef_a = r_evening_first;
                    n_ramp_req.coef_b = r_evening_last;
                    n_ramp_req.op_a   = ni - r_mod;
                    n_ramp_req.op_b   = r_mod - ev;
                    n_ramp_req.den    = ni - ev;
                    n_ramp_start      = 1'b1;
                    n_state           = S_RAMP;
                end
            end
            S_RAMP: begin
                if (ramp_done) begin
                    n_target = ramp_quotient;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_ramp_start    <= 1'b0;
            r_out_valid     <= 1'b0;
            r_faded         <= '0;
            r_morning_hour  <= 5'd6;
            r_day_hour      <= 5'd8;
            r_evening_hour  <= 5'd18;
            r_night_hour    <= 5'd23;
            r_morning_level <= 7'd90;
            r_day_level     <= 7'd90;
            r_evening_first <= 7'd60;
            r_evening_last  <= 7'd25;
        end else begin
            r_state      <= n_state;
            r_ramp_start <= n_ramp_start;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
                r_faded     <= faded_next;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                case (i_cfg.data.index)
                    tods_pkg::REG_MORNING_BEGIN_HOUR:  r_morning_hour  <= cfg_hour;
                    tods_pkg::REG_DAY_BEGIN_HOUR:      r_day_hour      <= cfg_hour;
                    tods_pkg::REG_EVENING_BEGIN_HOUR:  r_evening_hour  <= cfg_hour;
                    tods_pkg::REG_NIGHT_BEGIN_HOUR:    r_night_hour    <= cfg_hour;
                    tods_pkg::REG_MORNING_LEVEL:       r_morning_level <= cfg_level;
                    tods_pkg::REG_DAY_LEVEL:           r_day_level     <= cfg_level;
                    tods_pkg::REG_EVENING_FIRST_LEVEL: r_evening_first <= cfg_level;
                    tods_pkg::REG_EVENING_LAST_LEVEL:  r_evening_last  <= cfg_level;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_target   <= n_target;
        r_window   <= n_window;
        r_ramp_req <= n_ramp_req;
        if (r_state == S_IDLE && i_item.valid) begin
            r_mod        <= hour_minutes(i_item.data.hour)
                            + tods_pkg::MinuteDayWidth'(i_item.data.minute);
            r_time_valid <= i_item.data.time_valid;
        end
        if (r_state == S_DONE && out_free) begin
            r_out_item.target_level <= r_target;
            r_out_item.shown_level  <= faded_next;
            r_out_item.window       <= r_window;
        end
    end

    tods_ramp_unit u_ramp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_ramp_start),
        .i_req      (r_ramp_req),
        .o_done     (ramp_done),
        .o_quotient (ramp_quotient)
    );

    assign i_item.ready   = (r_state == S_IDLE);
    assign i_cfg.ready    = 1'b1;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out_item;

endmodule
